[hw/rtl/sbpa_pkg.sv]
// Shared types and constants of the spectrum bin peak accumulator.
// Holds the field types, request codes and register indexes; no dependencies.
package sbpa_pkg;

   localparam int MZ_W    = 24;
   localparam int BIN_W   = 19;
   localparam int PEAK_W  = 32;
   localparam int SLOT_W  = 12;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic [MZ_W-1:0]          mz_type;
   typedef logic [BIN_W-1:0]         bin_type;
   typedef logic signed [PEAK_W-1:0] peak_type;
   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic [KIND_W-1:0]        kind_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   // Request codes.
   localparam kind_type REQ_ADD   = 2'd0;
   localparam kind_type REQ_READ  = 2'd1;
   localparam kind_type REQ_CLEAR = 2'd2;

   // Register indexes.
   localparam csr_idx_type CSR_FIRST_BIN   = 3'd0;
   localparam csr_idx_type CSR_LAST_BIN    = 3'd1;
   localparam csr_idx_type CSR_WIN_LOW     = 3'd2;
   localparam csr_idx_type CSR_WIN_HIGH    = 3'd3;
   localparam csr_idx_type CSR_WIN_LOW_ON  = 3'd4;
   localparam csr_idx_type CSR_WIN_HIGH_ON = 3'd5;

   // Register reset values.
   localparam bin_type FIRST_BIN_RST = 19'd0;
   localparam bin_type LAST_BIN_RST  = 19'd4095;
   localparam mz_type  WIN_LOW_RST   = 24'd0;
   localparam mz_type  WIN_HIGH_RST  = 24'hFFFFFF;

   // Magnitude as an unsigned value; the most negative number maps to 2^31.
   function automatic logic [PEAK_W-1:0] magnitude(input peak_type v);
      logic [PEAK_W-1:0] u;
      u = v;
      return u[PEAK_W-1] ? (~u + {{(PEAK_W-1){1'b0}}, 1'b1}) : u;
   endfunction

endpackage

[hw/rtl/spectrum_bin_peak_accumulator_unit.sv]
// Spectrum bin peak accumulator: overlays points into 0.2-wide m/z bins.
// Depends on sbpa_pkg; holds the bin store as one synchronous memory.
//
//   Channel  Direction  Ports
//   req      in         req_valid, req_stall, req_type, req_mz, req_intensity, req_read_slot
//   rsp      out        rsp_valid, rsp_stall, rsp_accepted, rsp_occupied, rsp_bin_number,
//                       rsp_peak
//   csr      in         csr_we, csr_index, csr_wdata
//
// An add runs bin calculation, memory read and modify/write-back into the output register:
// its response becomes valid once the write-back step fires, and the next request is taken from then on.
// A read skips the bin calculation; a clear or unknown request answers without the calculation or the read.
// A clear then sweeps the store, one entry per cycle; reset runs the same sweep.
// A stalled response holds the unit in its last step; a new request is still taken
// while an earlier response waits in the output register.
module spectrum_bin_peak_accumulator_unit #(
   parameter int NUM_BINS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sbpa_pkg::kind_type     req_type,
   input  sbpa_pkg::mz_type       req_mz,
   input  sbpa_pkg::peak_type     req_intensity,
   input  sbpa_pkg::slot_type     req_read_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_accepted,
   output logic                   rsp_occupied,
   output sbpa_pkg::bin_type      rsp_bin_number,
   output sbpa_pkg::peak_type     rsp_peak,
   input  logic                   csr_we,
   input  sbpa_pkg::csr_idx_type  csr_index,
   input  sbpa_pkg::csr_data_type csr_wdata
);
   import sbpa_pkg::*;

   localparam int IDX_W = $clog2(NUM_BINS);
   localparam int WIDE_W = SLOT_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);
   localparam bin_type LAST_IDX_BIN = BIN_W'(NUM_BINS - 1);
   localparam logic [WIDE_W-1:0] NUM_BINS_WIDE = WIDE_W'(NUM_BINS);

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CALC  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // Configuration registers.
   bin_type first_bin_ff, last_bin_ff;
   mz_type  win_low_ff, win_high_ff;
   logic    win_low_on_ff, win_high_on_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bin_ff   <= FIRST_BIN_RST;
         last_bin_ff    <= LAST_BIN_RST;
         win_low_ff     <= WIN_LOW_RST;
         win_high_ff    <= WIN_HIGH_RST;
         win_low_on_ff  <= 1'b0;
         win_high_on_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_BIN:   first_bin_ff   <= csr_wdata[BIN_W-1:0];
            CSR_LAST_BIN:    last_bin_ff    <= csr_wdata[BIN_W-1:0];
            CSR_WIN_LOW:     win_low_ff     <= csr_wdata;
            CSR_WIN_HIGH:    win_high_ff    <= csr_wdata;
            CSR_WIN_LOW_ON:  win_low_on_ff  <= csr_wdata[0];
            CSR_WIN_HIGH_ON: win_high_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Request payload and per-step results.
   kind_type         kind_ff;
   mz_type           mz_ff;
   peak_type         inten_ff;
   slot_type         slot_ff;
   bin_type          bin_ff;
   logic             ok_ff;
   logic [IDX_W-1:0] hi_ff;
   logic [IDX_W-1:0] addr_ff;
   logic             rd_used_ff;
   peak_type         rd_peak_ff;

   // Output register.
   logic             out_acc_ff, out_occ_ff;
   bin_type          out_bin_ff;
   peak_type         out_peak_ff;
   logic             out_acc_in, out_occ_in;
   bin_type          out_bin_in;
   peak_type         out_peak_in;

   // Bin store: occupied flag above the peak.
   logic [PEAK_W:0]  mem [NUM_BINS];

   logic req_fire, fire;
   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Bin calculation: round(5*mz/256) with halves rounding up.
   logic [MZ_W+2:0] scaled;
   logic            in_win;
   bin_type         span;
   assign scaled = (MZ_W+3)'({mz_ff, 2'b00}) + (MZ_W+3)'(mz_ff) + (MZ_W+3)'(128);
   assign in_win = (!win_low_on_ff || mz_ff >= win_low_ff) &&
                   (!win_high_on_ff || mz_ff <= win_high_ff);
   assign span   = last_bin_ff - first_bin_ff;

   // Offset into the store, clamped to the kept range.
   bin_type          off;
   logic [IDX_W-1:0] off_cl;
   logic [WIDE_W-1:0] slot_wide;
   logic [IDX_W-1:0] rd_addr;
   assign off       = (bin_ff < first_bin_ff) ? '0 : bin_ff - first_bin_ff;
   assign off_cl    = (off > BIN_W'(hi_ff)) ? hi_ff : off[IDX_W-1:0];
   assign slot_wide = {{IDX_W{1'b0}}, slot_ff};
   assign rd_addr   = (kind_ff == REQ_ADD) ? off_cl : slot_wide[IDX_W-1:0];

   // Modify step.
   logic     slot_ok;
   peak_type new_peak;
   logic     wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [PEAK_W:0]  wr_data;
   assign slot_ok  = (slot_wide < NUM_BINS_WIDE);
   assign new_peak = (!rd_used_ff || (magnitude(inten_ff) > magnitude(rd_peak_ff)))
                     ? inten_ff : rd_peak_ff;
   assign wr_en    = (state_ff == ST_SWEEP) ||
                     (fire && (kind_ff == REQ_ADD) && ok_ff);
   assign wr_addr  = (state_ff == ST_SWEEP) ? sweep_ff : addr_ff;
   assign wr_data  = (state_ff == ST_SWEEP) ? '0 : {1'b1, new_peak};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         {rd_used_ff, rd_peak_ff} <= mem[rd_addr];
         addr_ff <= rd_addr;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_type)
                  REQ_ADD:  state_in = ST_CALC;
                  REQ_READ: state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_CALC: state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               sweep_in     = '0;
               state_in     = (kind_ff == REQ_CLEAR) ? ST_SWEEP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_type;
         mz_ff    <= req_mz;
         inten_ff <= req_intensity;
         slot_ff  <= req_read_slot;
      end
      if (state_ff == ST_CALC) begin
         bin_ff <= scaled[MZ_W+2:8];
         ok_ff  <= in_win && (first_bin_ff <= last_bin_ff);
         hi_ff  <= (span > LAST_IDX_BIN) ? LAST_IDX : span[IDX_W-1:0];
      end
   end

   always_comb begin
      out_acc_in  = 1'b0;
      out_occ_in  = 1'b0;
      out_bin_in  = '0;
      out_peak_in = '0;
      unique case (kind_ff)
         REQ_ADD: begin
            if (ok_ff) begin
               out_acc_in  = 1'b1;
               out_occ_in  = 1'b1;
               out_bin_in  = first_bin_ff + BIN_W'(addr_ff);
               out_peak_in = new_peak;
            end
         end
         REQ_READ: begin
            out_bin_in = first_bin_ff + BIN_W'(slot_ff);
            if (slot_ok && rd_used_ff) begin
               out_occ_in  = 1'b1;
               out_peak_in = rd_peak_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_acc_ff  <= out_acc_in;
         out_occ_ff  <= out_occ_in;
         out_bin_ff  <= out_bin_in;
         out_peak_ff <= out_peak_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = out_acc_ff;
   assign rsp_occupied   = out_occ_ff;
   assign rsp_bin_number = out_bin_ff;
   assign rsp_peak       = out_peak_ff;

endmodule

[tb/sv/bin_peak_check_pkg.sv]
// Scoreboard for the spectrum bin peak accumulator: predicts each response from
// accepted requests and compares it field by field. Depends on sbpa_pkg.
package bin_peak_check_pkg;
   import sbpa_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam kind_type REQ_UNUSED = 2'd3;

   typedef struct {
      logic     accepted;
      logic     occupied;
      bin_type  bin_number;
      peak_type peak;
   } bin_report_type;

   class bin_peak_scoreboard;
      bin_type  first_bin   = FIRST_BIN_RST;
      bin_type  last_bin    = LAST_BIN_RST;
      mz_type   win_low     = WIN_LOW_RST;
      mz_type   win_high    = WIN_HIGH_RST;
      bit       win_low_on  = 1'b0;
      bit       win_high_on = 1'b0;
      bit       used[STORE_DEPTH];
      peak_type peaks[STORE_DEPTH];
      // Entries whose peak has been written at least once since reset.
      bit       written[STORE_DEPTH];
      slot_type written_slots[$];
      bin_report_type pending_reports[$];
      int unsigned failures = 0;

      function int unsigned outstanding();
         return pending_reports.size();
      endfunction

      function slot_type pick_written_slot();
         if (written_slots.size() == 0)
            return '0;
         return written_slots[$urandom_range(written_slots.size() - 1)];
      endfunction

      // The most negative intensity has a magnitude of 2^31, so one extra bit is kept.
      function logic [32:0] magnitude_of(peak_type v);
         logic signed [32:0] w;
         w = v;
         return (w < 0) ? -w : w;
      endfunction

      function void set_register(csr_idx_type idx, csr_data_type value);
         case (idx)
            CSR_FIRST_BIN:   first_bin = value[BIN_W-1:0];
            CSR_LAST_BIN:    last_bin = value[BIN_W-1:0];
            CSR_WIN_LOW:     win_low = value[MZ_W-1:0];
            CSR_WIN_HIGH:    win_high = value[MZ_W-1:0];
            CSR_WIN_LOW_ON:  win_low_on = value[0];
            CSR_WIN_HIGH_ON: win_high_on = value[0];
            default: ;
         endcase
      endfunction

      function void note_request(kind_type kind, mz_type mz, peak_type intensity,
                                 slot_type slot);
         bin_report_type rep;
         int unsigned bin, offset, top;
         bit in_window;
         rep = '{1'b0, 1'b0, '0, '0};
         case (kind)
            REQ_ADD: begin
               in_window = (!win_low_on || mz >= win_low) && (!win_high_on || mz <= win_high);
               if (in_window && first_bin <= last_bin) begin
                  bin = (32'd5 * mz + 32'd128) >> 8;
                  offset = (bin < first_bin) ? 0 : bin - first_bin;
                  top = last_bin - first_bin;
                  if (top > STORE_DEPTH - 1)
                     top = STORE_DEPTH - 1;
                  if (offset > top)
                     offset = top;
                  // A point landing in an empty entry is stored without comparison.
                  if (!used[offset]) begin
                     used[offset] = 1'b1;
                     peaks[offset] = intensity;
                  end else if (magnitude_of(intensity) > magnitude_of(peaks[offset])) begin
                     peaks[offset] = intensity;
                  end
                  if (!written[offset]) begin
                     written[offset] = 1'b1;
                     written_slots = {written_slots, slot_type'(offset)};
                  end
                  rep.accepted = 1'b1;
                  rep.occupied = 1'b1;
                  rep.bin_number = bin_type'(first_bin + offset);
                  rep.peak = peaks[offset];
               end
            end
            REQ_READ: begin
               rep.bin_number = bin_type'(first_bin + slot);
               if (slot < STORE_DEPTH && used[slot]) begin
                  rep.occupied = 1'b1;
                  rep.peak = peaks[slot];
               end
            end
            REQ_CLEAR: begin
               foreach (used[i])
                  used[i] = 1'b0;
            end
            default: ;
         endcase
         pending_reports = {pending_reports, rep};
      endfunction

      function void compare_field(string name, logic signed [63:0] expected,
                                  logic signed [63:0] actual);
         if (expected !== actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            failures++;
         end
      endfunction

      function void check_report(logic accepted, logic occupied, bin_type bin_number,
                                 peak_type peak);
         bin_report_type want;
         if (pending_reports.size() == 0) begin
            $error("response arrived with no request outstanding");
            failures++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("accepted", want.accepted, accepted);
         compare_field("occupied", want.occupied, occupied);
         compare_field("bin_number", want.bin_number, bin_number);
         compare_field("peak", want.peak, peak);
      endfunction
   endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench of the spectrum bin peak accumulator: directed and random
// requests over several register settings. Depends on sbpa_pkg and bin_peak_check_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sbpa_pkg::*;
   import bin_peak_check_pkg::*;

   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int unsigned MZ_MAX = 24'hFFFFFF;
   localparam peak_type PEAK_MIN = 32'h80000000;
   localparam peak_type PEAK_MAX = 32'h7FFFFFFF;

   typedef struct {
      int unsigned first;
      int unsigned last;
      int unsigned win_low;
      int unsigned win_high;
      bit          low_on;
      bit          high_on;
      int unsigned hot;
   } bin_setup_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   kind_type     req_type = REQ_ADD;
   mz_type       req_mz = '0;
   peak_type     req_intensity = '0;
   slot_type     req_read_slot = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic         rsp_accepted;
   logic         rsp_occupied;
   bin_type      rsp_bin_number;
   peak_type     rsp_peak;
   logic         csr_we = 1'b0;
   csr_idx_type  csr_index = CSR_FIRST_BIN;
   csr_data_type csr_wdata = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   bin_peak_scoreboard sb = new();

   spectrum_bin_peak_accumulator_unit #(
      .NUM_BINS(STORE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_mz         (req_mz),
      .req_intensity  (req_intensity),
      .req_read_slot  (req_read_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_occupied   (rsp_occupied),
      .rsp_bin_number (rsp_bin_number),
      .rsp_peak       (rsp_peak),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_report(rsp_accepted, rsp_occupied, rsp_bin_number, rsp_peak);
   end

   // An m/z near the middle of the given bin, saturated to the field width.
   function automatic mz_type mz_of_bin(int unsigned bin);
      int unsigned m;
      m = (bin * 256 + 2) / 5;
      return (m > MZ_MAX) ? mz_type'(MZ_MAX) : mz_type'(m);
   endfunction

   function automatic bin_setup_type phase_setup(int p);
      case (p)
         1: return '{0, 4095, 0, MZ_MAX, 1'b0, 1'b0, 100};
         2: return '{1000, 1200, mz_of_bin(1050), mz_of_bin(1150), 1'b1, 1'b1, 1060};
         3: return '{300000, 327680, mz_of_bin(300100), MZ_MAX, 1'b1, 1'b0, 300090};
         4: return '{327680, 327680, 0, MZ_MAX, 1'b0, 1'b0, 327670};
         5: return '{500, 100, 0, MZ_MAX, 1'b1, 1'b1, 300};
         6: return '{0, 0, MZ_MAX, 0, 1'b1, 1'b0, 0};
         7: return '{2000, 6095, 0, mz_of_bin(4000), 1'b0, 1'b1, 3990};
         default: return '{0, 4095, 0, MZ_MAX, 1'b0, 1'b0, 4080};
      endcase
   endfunction

   function automatic peak_type pick_intensity();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40)
         return peak_type'($urandom);
      if (r < 70)
         return peak_type'(int'($urandom_range(16)) - 8);
      if (r < 78)
         return PEAK_MIN;
      if (r < 86)
         return PEAK_MAX;
      if (r < 92)
         return -PEAK_MAX;
      return '0;
   endfunction

   // Most points fall on a few bins near the hot spot so that peaks compete;
   // the rest probe the range ends, the window edges and the whole m/z field.
   function automatic mz_type pick_mz(bin_setup_type s);
      int unsigned r, bin;
      int m;
      r = $urandom_range(99);
      if (r < 55) begin
         bin = s.hot + $urandom_range(23);
      end else if (r < 68) begin
         bin = s.first + $urandom_range(4200);
      end else if (r < 78) begin
         bin = s.last + $urandom_range(8);
         bin = (bin > 4) ? bin - 4 : 0;
      end else if (r < 85) begin
         bin = (s.first > 8) ? s.first - $urandom_range(8) : $urandom_range(8);
      end else if (r < 92) begin
         m = int'($urandom_range(1) ? s.win_low : s.win_high) + int'($urandom_range(2)) - 1;
         if (m < 0)
            m = 0;
         if (m > int'(MZ_MAX))
            m = MZ_MAX;
         return mz_type'(m);
      end else begin
         case ($urandom_range(2))
            0: return mz_type'(MZ_MAX);
            1: return '0;
            default: return mz_type'($urandom_range(MZ_MAX));
         endcase
      end
      return mz_of_bin(bin);
   endfunction

   task automatic send_request(kind_type kind, mz_type mz, peak_type intensity,
                               slot_type slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_mz <= mz;
      req_intensity <= intensity;
      req_read_slot <= slot;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(kind, mz, intensity, slot);
   endtask

   task automatic random_request(bin_setup_type s);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 4)
         send_request(REQ_CLEAR, mz_type'($urandom), peak_type'($urandom),
                      sb.pick_written_slot());
      else if (r < 7)
         send_request(REQ_UNUSED, mz_type'($urandom), peak_type'($urandom),
                      sb.pick_written_slot());
      else if (r < 30)
         send_request(REQ_READ, mz_type'($urandom), peak_type'($urandom),
                      sb.pick_written_slot());
      else
         send_request(REQ_ADD, pick_mz(s), pick_intensity(), sb.pick_written_slot());
   endtask

   // A clear keeps sweeping the store after its response, so allow a full sweep.
   task automatic wait_drained();
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (STORE_DEPTH + 16) @(posedge clock);
   endtask

   task automatic write_register(csr_idx_type idx, csr_data_type value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic configure(bin_setup_type s);
      write_register(CSR_FIRST_BIN, csr_data_type'(s.first));
      write_register(CSR_LAST_BIN, csr_data_type'(s.last));
      write_register(CSR_WIN_LOW, csr_data_type'(s.win_low));
      write_register(CSR_WIN_HIGH, csr_data_type'(s.win_high));
      write_register(CSR_WIN_LOW_ON, csr_data_type'(s.low_on));
      write_register(CSR_WIN_HIGH_ON, csr_data_type'(s.high_on));
      csr_we <= 1'b0;
   endtask

   initial begin
      bin_setup_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings.
      send_request(REQ_ADD, '0, PEAK_MAX, '0);
      send_request(REQ_ADD, '0, PEAK_MIN, '0);
      send_request(REQ_ADD, 24'd1, PEAK_MAX, '0);
      send_request(REQ_ADD, mz_of_bin(1), 32'sd5, '0);
      send_request(REQ_ADD, mz_of_bin(1), -32'sd5, '0);
      send_request(REQ_ADD, 24'd127, -32'sd8, '0);
      // Exactly half way between bins two and three: rounds up.
      send_request(REQ_ADD, 24'd128, 32'sd8, '0);
      send_request(REQ_ADD, mz_type'(MZ_MAX), -32'sd1, '0);
      send_request(REQ_ADD, mz_of_bin(4095), -32'sd2, '0);
      send_request(REQ_ADD, mz_of_bin(12'hAAA), peak_type'($urandom), '0);
      send_request(REQ_ADD, mz_of_bin(12'h555), peak_type'($urandom), '0);
      send_request(REQ_READ, '0, '0, 12'h000);
      send_request(REQ_READ, '0, '0, 12'hFFF);
      send_request(REQ_READ, '0, '0, 12'hAAA);
      send_request(REQ_READ, '0, '0, 12'h555);
      send_request(REQ_READ, '0, '0, 12'd3);
      send_request(REQ_READ, '0, '0, 12'd2);
      send_request(REQ_UNUSED, mz_type'(MZ_MAX), peak_type'(32'hFFFFFFFF), 12'hFFF);
      send_request(REQ_CLEAR, '0, '0, '0);
      send_request(REQ_READ, '0, '0, 12'h000);
      send_request(REQ_READ, '0, '0, 12'hFFF);
      send_request(REQ_ADD, '0, 32'sd3, '0);
      send_request(REQ_READ, '0, '0, 12'h000);
      send_request(REQ_READ, '0, '0, 12'd1);
      req_valid <= 1'b0;

      for (int p = 1; p <= PHASES; p++) begin
         wait_drained();
         s = phase_setup(p);
         configure(s);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle_pct = 30;
               stall_pct = 30;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_request(s);
         req_valid <= 1'b0;
      end

      stall_pct = 0;
      wait_drained();
      if (sb.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end

endmodule
